@@ src/roi_binned_histogram_accumulator_unit_defines.svh @@
// ----------------------------------------------------------------------------
// ROI histogram accumulator assertion macros
// Concurrent assertion shorthands shared by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef ROI_BINNED_HISTOGRAM_ACCUMULATOR_UNIT_DEFINES_SVH
`define ROI_BINNED_HISTOGRAM_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RBHA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RBHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/rbha_pkg.sv @@
// ----------------------------------------------------------------------------
// ROI histogram accumulator package
// Sizes, codes and the types that pass between the front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package rbha_pkg;

	// Geometry and storage
	localparam int BINS        = 4096;
	localparam int BIN_W       = $clog2(BINS);
	localparam int ROW_PITCH   = 160;
	localparam int ROWS        = 120;
	localparam int CHANNELS    = 4;
	localparam int CH_W        = 2;
	localparam int COUNT_W     = 32;
	localparam int FRAME_W     = 16;
	localparam int ORIGIN_W    = 15;

	// Command queue depth, a power of two
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);

	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS - 1);

	// Input item kinds
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_SAMPLE = 2'd0;
	localparam kind_t KIND_FRAME  = 2'd1;
	localparam kind_t KIND_READ   = 2'd2;
	localparam kind_t KIND_CLEAR  = 2'd3;

	// Back-end operations
	typedef logic [1:0] op_t;
	localparam op_t OP_SAMPLE = 2'd0;
	localparam op_t OP_FRAME  = 2'd1;
	localparam op_t OP_READ   = 2'd2;
	localparam op_t OP_CLEAR  = 2'd3;

	// Result kinds
	localparam logic RES_FRAME = 1'b0;
	localparam logic RES_READ  = 1'b1;

	// Window size codes
	localparam logic [1:0] MODE_OFF = 2'd3;

	typedef struct packed {
		logic [1:0]                         window_mode;
		logic [FRAME_W-1:0]                 frames_per_histogram;
		logic                               stream_enable;
		logic [CHANNELS-1:0][ORIGIN_W-1:0]  origin;
	} cfg_t;

	typedef struct packed {
		op_t                 op;
		logic [CHANNELS-1:0] mask;
		logic [CH_W-1:0]     channel;
		logic [BIN_W-1:0]    bin;
		logic [FRAME_W-1:0]  frame_number;
		logic                done;
		logic                report;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic init_busy;
		logic sweeping;
		logic pop;
	} bstat_t;

endpackage

`default_nettype wire

@@ src/roi_binned_histogram_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// ROI binned histogram accumulator
// Four-channel windowed timing histogram with frame counting, bin readout and
// an APB-style register port.
// ----------------------------------------------------------------------------
// Samples, bin reads and frame reports sustain one item per cycle while no sweep
// runs and no result waits on out_ready: each goes through a four-entry command
// queue into a two-stage read-modify-write pipeline over the per-channel bin
// memories, with the previous write forwarded so that repeated bins need no
// bubbles. A clear-all item, or an end of frame that completes the period,
// starts a sweep that zeroes one bin of every channel per cycle over all bins;
// later items queue up behind it and input stalls once the queue is full.
// After reset the same clearing pass runs with in_ready low; register writes
// are taken throughout.
`default_nettype none

`include "roi_binned_histogram_accumulator_unit_defines.svh"

module roi_binned_histogram_accumulator_unit import rbha_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Register port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// Input items
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [1:0]   kind,
	input  wire logic [6:0]   pixel_row,
	input  wire logic [7:0]   pixel_col,
	input  wire logic [11:0]  sample_value,
	input  wire logic [1:0]   read_channel,
	input  wire logic [11:0]  read_bin,
	// Results
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic              result_kind,
	output logic [15:0]       frame_number,
	output logic              period_done,
	output logic [31:0]       bin_count
);

	localparam logic [2:0] REG_WINDOW_MODE   = 3'd0;
	localparam logic [2:0] REG_FRAMES_PER    = 3'd1;
	localparam logic [2:0] REG_STREAM_ENABLE = 3'd2;
	localparam logic [2:0] REG_ORIGIN_CH0    = 3'd3;
	localparam logic [2:0] REG_ORIGIN_CH1    = 3'd4;
	localparam logic [2:0] REG_ORIGIN_CH2    = 3'd5;
	localparam logic [2:0] REG_ORIGIN_CH3    = 3'd6;

	cfg_t        cfg_q;
	logic        wr_en;
	logic [2:0]  reg_idx;
	logic        q_push;
	cmd_t        q_cmd;
	cmd_t        q_head;
	qstat_t      qstat;
	bstat_t      bstat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WINDOW_MODE:   cfg_q.window_mode          <= pwdata[1:0];
				REG_FRAMES_PER:    cfg_q.frames_per_histogram <= pwdata[FRAME_W-1:0];
				REG_STREAM_ENABLE: cfg_q.stream_enable        <= pwdata[0];
				REG_ORIGIN_CH0:    cfg_q.origin[0]            <= pwdata[ORIGIN_W-1:0];
				REG_ORIGIN_CH1:    cfg_q.origin[1]            <= pwdata[ORIGIN_W-1:0];
				REG_ORIGIN_CH2:    cfg_q.origin[2]            <= pwdata[ORIGIN_W-1:0];
				REG_ORIGIN_CH3:    cfg_q.origin[3]            <= pwdata[ORIGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (reg_idx)
			REG_WINDOW_MODE:   prdata = 32'(cfg_q.window_mode);
			REG_FRAMES_PER:    prdata = 32'(cfg_q.frames_per_histogram);
			REG_STREAM_ENABLE: prdata = 32'(cfg_q.stream_enable);
			REG_ORIGIN_CH0:    prdata = 32'(cfg_q.origin[0]);
			REG_ORIGIN_CH1:    prdata = 32'(cfg_q.origin[1]);
			REG_ORIGIN_CH2:    prdata = 32'(cfg_q.origin[2]);
			REG_ORIGIN_CH3:    prdata = 32'(cfg_q.origin[3]);
			default:           prdata = '0;
		endcase
	end

	rbha_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.pixel_row    (pixel_row),
		.pixel_col    (pixel_col),
		.sample_value (sample_value),
		.read_channel (read_channel),
		.read_bin     (read_bin),
		.qstat        (qstat),
		.bstat        (bstat),
		.q_push       (q_push),
		.q_cmd        (q_cmd)
	);

	rbha_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (bstat.pop),
		.head     (q_head),
		.qstat    (qstat)
	);

	rbha_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.qstat        (qstat),
		.bstat        (bstat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.frame_number (frame_number),
		.period_done  (period_done),
		.bin_count    (bin_count)
	);

	// Checks
	`RBHA_ASSERT_NOW(a_queue_no_overflow, clk, arst_n, q_push, !qstat.full, "push into full queue")
	`RBHA_ASSERT_NOW(a_no_pop_in_sweep, clk, arst_n, bstat.sweeping, !bstat.pop, "pop during sweep")
	`RBHA_ASSERT_NOW(a_read_fields, clk, arst_n, out_valid && (result_kind == RES_READ), (frame_number == '0) && !period_done, "read result carries frame fields")
	`RBHA_ASSERT_NEXT(a_quiet_init, clk, arst_n, bstat.init_busy, !out_valid, "result during reset clear")

endmodule

`default_nettype wire

@@ src/rbha_front.sv @@
// ----------------------------------------------------------------------------
// ROI histogram accumulator front end
// Accepts input items, matches samples against the channel windows, keeps the
// frame counter and queues one command per item that has an effect.
// ----------------------------------------------------------------------------
`default_nettype none

module rbha_front import rbha_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_t                 cfg,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           kind,
	input  wire logic [6:0]           pixel_row,
	input  wire logic [7:0]           pixel_col,
	input  wire logic [11:0]          sample_value,
	input  wire logic [1:0]           read_channel,
	input  wire logic [11:0]          read_bin,
	input  wire qstat_t               qstat,
	input  wire bstat_t               bstat,
	output logic                      q_push,
	output cmd_t                      q_cmd
);

	logic [FRAME_W-1:0]  frame_cnt_q;
	logic [FRAME_W-1:0]  frame_next;
	logic                frame_done;
	logic                accept;
	logic                need_push;
	logic [2:0]          size;
	logic [CHANNELS-1:0] hit;
	logic                on_sensor;

	// Take items while the queue has room and the reset clear is finished
	assign in_ready = !qstat.full && !bstat.init_busy;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && need_push;

	// Window match for every channel
	always_comb begin
		logic [6:0] orow;
		logic [7:0] ocol;
		logic [7:0] row_end;
		logic [8:0] col_end;
		size      = 3'd1 << cfg.window_mode;
		on_sensor = ({1'b0, pixel_row} < 8'(ROWS)) && ({1'b0, pixel_col} < 9'(ROW_PITCH));
		for (int ch = 0; ch < CHANNELS; ch++) begin
			orow    = cfg.origin[ch][14:8];
			ocol    = cfg.origin[ch][7:0];
			row_end = {1'b0, orow} + 8'(size);
			col_end = {1'b0, ocol} + 9'(size);
			hit[ch] = (cfg.window_mode != MODE_OFF) && on_sensor
				&& (col_end <= 9'(ROW_PITCH)) && (row_end <= 8'(ROWS))
				&& (pixel_row >= orow) && ({1'b0, pixel_row} < row_end)
				&& (pixel_col >= ocol) && ({1'b0, pixel_col} < col_end);
		end
	end

	assign frame_next = frame_cnt_q + 1'b1;
	assign frame_done = frame_next >= cfg.frames_per_histogram;

	// Classify the item into a back-end command
	always_comb begin
		q_cmd              = '0;
		q_cmd.bin          = sample_value[BIN_W-1:0];
		q_cmd.mask         = hit;
		need_push          = 1'b0;
		unique case (kind)
			KIND_SAMPLE: begin
				q_cmd.op  = OP_SAMPLE;
				need_push = |hit;
			end
			KIND_FRAME: begin
				q_cmd.op           = frame_done ? OP_CLEAR : OP_FRAME;
				q_cmd.mask         = '0;
				q_cmd.frame_number = frame_next;
				q_cmd.done         = frame_done;
				q_cmd.report       = cfg.stream_enable;
				need_push          = frame_done || cfg.stream_enable;
			end
			KIND_READ: begin
				q_cmd.op      = OP_READ;
				q_cmd.mask    = '0;
				q_cmd.channel = read_channel;
				q_cmd.bin     = read_bin[BIN_W-1:0];
				need_push     = 1'b1;
			end
			default: begin
				q_cmd.op   = OP_CLEAR;
				q_cmd.mask = '0;
				need_push  = 1'b1;
			end
		endcase
	end

	// Advance or clear the frame counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cnt_q <= '0;
		end else if (accept) begin
			if (kind == KIND_FRAME) begin
				frame_cnt_q <= frame_done ? '0 : frame_next;
			end else if (kind == KIND_CLEAR) begin
				frame_cnt_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/rbha_queue.sv @@
// ----------------------------------------------------------------------------
// ROI histogram accumulator command queue
// Short FIFO that decouples the front end from the memory back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rbha_queue import rbha_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire cmd_t   push_cmd,
	input  wire logic   pop,
	output cmd_t        head,
	output qstat_t      qstat
);

	cmd_t                entries_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign qstat.full  = count_q == (QPTR_W + 1)'(QDEPTH);
	assign qstat.empty = count_q == '0;
	assign head        = entries_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
		end
	end

endmodule

`default_nettype wire

@@ src/rbha_back.sv @@
// ----------------------------------------------------------------------------
// ROI histogram accumulator back end
// Per-channel bin memories with a two-stage read-modify-write pipeline, a
// clearing sweep and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbha_back import rbha_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cmd_t          head,
	input  wire qstat_t        qstat,
	output bstat_t             bstat,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               result_kind,
	output logic [15:0]        frame_number,
	output logic               period_done,
	output logic [31:0]        bin_count
);

	// Pipeline stages
	logic                 v_s1;
	logic                 v_s2;
	cmd_t                 cmd_s1;
	cmd_t                 cmd_s2;
	logic [COUNT_W-1:0]   rdata_s2 [CHANNELS];

	// Last write, for the read issued in the same cycle
	logic [CHANNELS-1:0]  byp_v_q;
	logic [BIN_W-1:0]     byp_addr_q;
	logic [COUNT_W-1:0]   byp_data_q [CHANNELS];

	// Clearing sweep
	logic                 sweep_q;
	logic                 init_q;
	logic [BIN_W-1:0]     sweep_cnt_q;

	// Result register
	logic                 out_valid_q;
	logic                 result_kind_q;
	logic [FRAME_W-1:0]   frame_number_q;
	logic                 period_done_q;
	logic [COUNT_W-1:0]   bin_count_q;

	logic                 res_s2;
	logic                 stall;
	logic                 pop;
	logic                 sample_s2;
	logic                 load;
	logic [COUNT_W-1:0]   cur [CHANNELS];
	logic [COUNT_W-1:0]   inc [CHANNELS];
	logic [CHANNELS-1:0]  wr_en;
	logic [BIN_W-1:0]     wr_addr;
	logic [COUNT_W-1:0]   wr_data [CHANNELS];

	// Stall only when a result waits on a full output register
	assign res_s2    = v_s2 && ((cmd_s2.op == OP_READ)
		|| (((cmd_s2.op == OP_FRAME) || (cmd_s2.op == OP_CLEAR)) && cmd_s2.report));
	assign stall     = res_s2 && out_valid_q && !out_ready;
	assign load      = res_s2 && !stall;
	assign sample_s2 = v_s2 && (cmd_s2.op == OP_SAMPLE);

	// Hold back new commands behind a clear until its sweep has run
	assign pop = !qstat.empty && !sweep_q && !stall
		&& !(v_s1 && (cmd_s1.op == OP_CLEAR))
		&& !(v_s2 && (cmd_s2.op == OP_CLEAR));

	assign bstat.init_busy = init_q;
	assign bstat.sweeping  = sweep_q;
	assign bstat.pop       = pop;

	// Current counts with the last write forwarded, and the saturated increment
	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			cur[ch] = (byp_v_q[ch] && (byp_addr_q == cmd_s2.bin)) ? byp_data_q[ch]
				: rdata_s2[ch];
			inc[ch] = (&cur[ch]) ? cur[ch] : cur[ch] + 1'b1;
		end
	end

	// Write port: sweep zeros, else sample increments
	always_comb begin
		wr_addr = sweep_q ? sweep_cnt_q : cmd_s2.bin;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			wr_en[ch]   = sweep_q || (sample_s2 && cmd_s2.mask[ch]);
			wr_data[ch] = sweep_q ? '0 : inc[ch];
		end
	end

	// Bin memories, one per channel, registered read held with its stage
	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_bank
		logic [COUNT_W-1:0] mem [BINS];
		always_ff @(posedge clk) begin
			if (wr_en[ch]) begin
				mem[wr_addr] <= wr_data[ch];
			end
			if (!stall) begin
				rdata_s2[ch] <= mem[cmd_s1.bin];
			end
		end
	end

	// Advance pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
		end
	end

	// Advance pipeline payload
	always_ff @(posedge clk) begin
		if (!stall) begin
			cmd_s2 <= cmd_s1;
			if (pop) begin
				cmd_s1 <= head;
			end
		end
	end

	// Track the last write; drop it once a sweep runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_v_q <= '0;
		end else if (sweep_q) begin
			byp_v_q <= '0;
		end else if (sample_s2) begin
			byp_v_q <= cmd_s2.mask;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_s2) begin
			byp_addr_q <= cmd_s2.bin;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				byp_data_q[ch] <= inc[ch];
			end
		end
	end

	// Sweep all bins after reset and after each clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= 1'b1;
			init_q      <= 1'b1;
			sweep_cnt_q <= '0;
		end else if (sweep_q) begin
			sweep_cnt_q <= sweep_cnt_q + 1'b1;
			if (sweep_cnt_q == LAST_BIN) begin
				sweep_q <= 1'b0;
				init_q  <= 1'b0;
			end
		end else if (!stall && v_s2 && (cmd_s2.op == OP_CLEAR)) begin
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (cmd_s2.op == OP_READ) begin
				result_kind_q  <= RES_READ;
				frame_number_q <= '0;
				period_done_q  <= 1'b0;
				bin_count_q    <= cur[cmd_s2.channel];
			end else begin
				result_kind_q  <= RES_FRAME;
				frame_number_q <= cmd_s2.frame_number;
				period_done_q  <= cmd_s2.done;
				bin_count_q    <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = result_kind_q;
	assign frame_number = frame_number_q;
	assign period_done  = period_done_q;
	assign bin_count    = bin_count_q;

endmodule

`default_nettype wire
